[design/dpc_pkg.sv]
package dpc_pkg;

  // field widths fixed by the item format
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned DEB_W    = 20;
  localparam int unsigned COUNT_W  = 8;

  // default button count
  localparam int unsigned NUM_BUTTONS_DEF = 5;

  // saturation point of the press counter
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // debounce interval after reset, in microseconds
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 20'd50000;

  // item modes
  localparam logic [MODE_W-1:0] MODE_LEVEL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CONSUME = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLEEP   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RESUME  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEED    = 3'd4;

  // configuration register indexes
  localparam logic REG_DEBOUNCE = 1'b0;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [IDX_W-1:0]     button_index;
    logic                 contact_closed;
    logic [TIME_BITS-1:0] time_us;
    logic                 woke_on_button;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] press_count;
    logic               any_pending;
  } out_item_t;

endpackage

[design/dpc_in_if.sv]
interface dpc_in_if;
  logic                           valid;
  logic                           ready;
  logic [dpc_pkg::MODE_W-1:0]     mode;
  logic [dpc_pkg::IDX_W-1:0]      button_index;
  logic                           contact_closed;
  logic [dpc_pkg::TIME_BITS-1:0]  time_us;
  logic                           woke_on_button;

  modport source (
    output valid, mode, button_index, contact_closed, time_us, woke_on_button,
    input  ready
  );
  modport sink (
    input  valid, mode, button_index, contact_closed, time_us, woke_on_button,
    output ready
  );
endinterface

[design/dpc_out_if.sv]
interface dpc_out_if;
  logic                         valid;
  logic                         ready;
  logic [dpc_pkg::COUNT_W-1:0]  press_count;
  logic                         any_pending;

  modport source (
    output valid, press_count, any_pending,
    input  ready
  );
  modport sink (
    input  valid, press_count, any_pending,
    output ready
  );
endinterface

[design/dpc_btn_bank.sv]
module dpc_btn_bank #(
  parameter int unsigned NUM_BUTTONS = dpc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  dpc_pkg::in_item_t             item_i,
  input  logic [dpc_pkg::DEB_W-1:0]     debounce_i,
  output dpc_pkg::out_item_t            res_o
);
  import dpc_pkg::*;

  logic                 closed_q [NUM_BUTTONS];
  logic                 closed_d [NUM_BUTTONS];
  logic [TIME_BITS-1:0] open_t_q [NUM_BUTTONS];
  logic [TIME_BITS-1:0] open_t_d [NUM_BUTTONS];
  logic [COUNT_W-1:0]   cnt_q    [NUM_BUTTONS];
  logic [COUNT_W-1:0]   cnt_d    [NUM_BUTTONS];
  logic [COUNT_W-1:0]   taken    [NUM_BUTTONS];

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
    logic                 sel;
    logic [TIME_BITS-1:0] elapsed;
    logic                 long_open;
    logic [COUNT_W-1:0]   bumped;

    assign sel       = (int'(item_i.button_index) == g);
    assign elapsed   = item_i.time_us - open_t_q[g];
    assign long_open = (elapsed >= TIME_BITS'(debounce_i));
    assign bumped    = (cnt_q[g] == COUNT_MAX) ? cnt_q[g] : cnt_q[g] + 8'd1;

    // count taken by a consume item
    assign taken[g] = (sel && item_i.mode == MODE_CONSUME) ? cnt_q[g] : '0;

    // per-button update for the item that hits this button
    always_comb begin
      closed_d[g] = closed_q[g];
      open_t_d[g] = open_t_q[g];
      cnt_d[g]    = cnt_q[g];
      if (accept_i && sel) begin
        unique case (item_i.mode)
          MODE_LEVEL: begin
            if (item_i.contact_closed) begin
              if (!closed_q[g] && long_open) cnt_d[g] = bumped;
              closed_d[g] = 1'b1;
            end else begin
              closed_d[g] = 1'b0;
              open_t_d[g] = item_i.time_us;
            end
          end
          MODE_CONSUME: begin
            cnt_d[g] = '0;
          end
          MODE_SLEEP: begin
            if (!item_i.contact_closed) begin
              closed_d[g] = 1'b0;
              open_t_d[g] = item_i.time_us;
            end
          end
          MODE_RESUME: begin
            if (item_i.woke_on_button && item_i.contact_closed && !closed_q[g]) begin
              cnt_d[g]    = bumped;
              closed_d[g] = 1'b1;
              open_t_d[g] = item_i.time_us;
            end
          end
          MODE_SEED: begin
            cnt_d[g]    = '0;
            open_t_d[g] = '0;
            closed_d[g] = item_i.contact_closed;
          end
          default: begin
          end
        endcase
      end
    end

    // button state
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        closed_q[g] <= 1'b0;
        open_t_q[g] <= '0;
        cnt_q[g]    <= '0;
      end else begin
        closed_q[g] <= closed_d[g];
        open_t_q[g] <= open_t_d[g];
        cnt_q[g]    <= cnt_d[g];
      end
    end
  end

  // result: taken count and pending flag after the update
  always_comb begin
    res_o.press_count = '0;
    res_o.any_pending = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      res_o.press_count = res_o.press_count | taken[i];
      res_o.any_pending = res_o.any_pending | (cnt_d[i] != '0);
    end
  end

endmodule

[design/dpc_out_skid.sv]
module dpc_out_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  dpc_pkg::out_item_t  res_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dpc_pkg::out_item_t  out_data_o
);
  import dpc_pkg::*;

  logic      out_v_q, out_v_d;
  logic      skid_v_q, skid_v_d;
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      pop;

  assign pop         = out_v_q && out_ready_i;
  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // output register with one skid entry behind it
  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (pop) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (accept_i) begin
      if (!out_v_q || pop) begin
        out_d   = res_i;
        out_v_d = 1'b1;
      end else begin
        skid_d   = res_i;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

[design/debounced_press_counter.sv]
// Debounced press counter for a bank of buttons.
// Items arrive on in_i (valid/ready); each carries a mode (level change,
// consume, prepare sleep, resume, seed), a button index, the sampled contact
// level, the current time in microseconds and a wake cause. Every item gives
// exactly one result on out_o: the count taken by a consume (0 otherwise) and
// a flag that is set while any button holds a nonzero count.
// The button state is updated at the transfer edge and the result is registered
// in the output buffer. One item per cycle is taken while in_i.ready is high;
// each item updates one button's flag, time stamp and counter.
// A two-entry output buffer (output register plus skid entry) lets a new item
// in while a result still waits; when both are full in_i.ready drops until
// out_o takes a result, and nothing is lost.
// Reset clears all flags, time stamps and counters and sets the debounce
// interval to 50000 us; pready is always high. The user must write the interval
// through the APB port at address 0 only while the block is idle (unchecked).
module debounced_press_counter #(
  parameter int unsigned NUM_BUTTONS = dpc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  dpc_in_if.sink                    in_i,
  dpc_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import dpc_pkg::*;

  logic             accept;
  logic             in_ready;
  in_item_t         item;
  out_item_t        res;
  out_item_t        out_data;
  logic [DEB_W-1:0] debounce_q;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_DEBOUNCE) begin
      debounce_q <= pwdata[DEB_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_DEBOUNCE) ? 32'(debounce_q) : '0;

  // input transfer
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;
  assign item = '{
    mode:           in_i.mode,
    button_index:   in_i.button_index,
    contact_closed: in_i.contact_closed,
    time_us:        in_i.time_us,
    woke_on_button: in_i.woke_on_button
  };

  dpc_btn_bank #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (item),
    .debounce_i(debounce_q),
    .res_o     (res)
  );

  dpc_out_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .res_i      (res),
    .in_ready_o (in_ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_data_o (out_data)
  );

  // result transfer
  assign out_o.press_count = out_data.press_count;
  assign out_o.any_pending = out_data.any_pending;

endmodule
